@@ design/block_ring_buffer_macros.svh @@
// Assertion macros shared by the ring buffer RTL.
// Included by the modules that carry concurrent assertions; depends on nothing.
`ifndef BLOCK_RING_BUFFER_MACROS_SVH
`define BLOCK_RING_BUFFER_MACROS_SVH
`ifndef ASSERT_OFF
`define RBUF_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define RBUF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define RBUF_ASSERT(lbl, clk, rstn, prop, msg)
`define RBUF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

@@ design/rbuf_pkg.sv @@
// Shared types and codes of the block ring buffer.
// Used by the front, job queue, back and top level; depends on nothing.
package rbuf_pkg;

  localparam int CMD_W      = 2;
  localparam int DATA_W     = 8;
  localparam int LEN_W      = 7;
  localparam int CNT_W      = 6;
  localparam int MISS_W     = 32;
  localparam int ST_W       = 2;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 7;

  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [ST_W-1:0] ST_ZERO  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BYTES = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_TOTAL = 4'd1;

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [LEN_W-1:0]  byte_count;
    logic [CNT_W-1:0]  blocks_readable;
    logic [CNT_W-1:0]  blocks_writable;
    logic [CNT_W-1:0]  contiguous_readable;
    logic [CNT_W-1:0]  contiguous_writable;
    logic [MISS_W-1:0] read_misses;
    logic [MISS_W-1:0] write_misses;
  } res_info_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_byte;
    logic              final_res;
    res_info_t         info;
  } res_t;

endpackage

@@ design/rbuf_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Used for the byte store; depends on nothing.
module rbuf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/rbuf_front.sv @@
// Front end: accepts requests, keeps the ring pointers, counters and sizes,
// writes bytes to the store and posts one job per result-bearing request.
// Depends on rbuf_pkg and the assertion macro header.
`include "block_ring_buffer_macros.svh"
module rbuf_front import rbuf_pkg::*; #(
  parameter int MAX_BLOCK_BYTES = 64,
  parameter int MAX_BLOCKS      = 64
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]                        cfg_index,
  input  logic [CFG_DATA_W-1:0]                       cfg_wdata,
  input  logic                                        push,
  output logic                                        full,
  input  logic [CMD_W-1:0]                            in_command,
  input  logic [DATA_W-1:0]                           in_data,
  input  logic                                        in_last,
  input  logic [LEN_W-1:0]                            in_read_length,
  input  logic                                        q_full,
  input  logic                                        q_hit,
  input  logic                                        bk_hit,
  output logic [$clog2(MAX_BLOCKS)-1:0]               wr_slot,
  output logic                                        jq_push,
  output res_info_t                                   jq_info,
  output logic                                        jq_rd,
  output logic [LEN_W-1:0]                            jq_len,
  output logic [$clog2(MAX_BLOCKS*MAX_BLOCK_BYTES)-1:0] jq_base,
  output logic [$clog2(MAX_BLOCKS)-1:0]               jq_slot,
  output logic                                        ram_we,
  output logic [$clog2(MAX_BLOCKS*MAX_BLOCK_BYTES)-1:0] ram_waddr,
  output logic [DATA_W-1:0]                           ram_wdata
);

  localparam int SD = MAX_BLOCKS * MAX_BLOCK_BYTES;
  localparam int AW = $clog2(SD);
  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int BB_RST = (MAX_BLOCK_BYTES < 64) ? MAX_BLOCK_BYTES : 64;
  localparam int BT_RST = (MAX_BLOCKS < 64) ? MAX_BLOCKS : 64;
  localparam logic [LEN_W-1:0] BB_RST_V = LEN_W'(BB_RST);
  localparam logic [LEN_W-1:0] BT_RST_V = LEN_W'(BT_RST);
  localparam logic [AW-1:0] LAST_ADDR = AW'(SD - 1);

  function automatic logic [7:0] idx_next(input logic [7:0] i, input logic [7:0] tot);
    logic [7:0] s;
    s = i + 8'd1;
    return (s >= tot) ? 8'd0 : s;
  endfunction

  logic [LEN_W-1:0]  bb_r, bb_nxt, bt_r, bt_nxt;
  logic [IW-1:0]     r_idx_r, r_idx_nxt, w_idx_r, w_idx_nxt;
  logic [AW-1:0]     rd_base_r, rd_base_nxt, wr_base_r, wr_base_nxt;
  logic [LEN_W-1:0]  fill_r, fill_nxt;
  logic [MISS_W-1:0] rmiss_r, rmiss_nxt, wmiss_r, wmiss_nxt;
  logic              clr_r, clr_nxt;
  logic [AW-1:0]     clr_addr_r, clr_addr_nxt;

  logic              accept, cfg_hit, do_store;
  logic [LEN_W-1:0]  fill_inc, rlen, bcnt, cv_bb, cv_bt;
  logic [ST_W-1:0]   st;
  logic [AW-1:0]     bb_a;
  logic [7:0]        t8, r8, w8, n8, nr8, r8n, w8n, n8n;

  assign full    = clr_r | q_full | q_hit | bk_hit;
  assign accept  = push & ~full;
  assign wr_slot = w_idx_r;
  assign cfg_hit = cfg_wr_en & (cfg_wdata != '0) &
                   ((cfg_index == REG_BLOCK_BYTES) || (cfg_index == REG_BLOCK_TOTAL));
  assign cv_bb = ({25'd0, cfg_wdata} > 32'(MAX_BLOCK_BYTES)) ? LEN_W'(MAX_BLOCK_BYTES) : cfg_wdata;
  assign cv_bt = ({25'd0, cfg_wdata} > 32'(MAX_BLOCKS)) ? LEN_W'(MAX_BLOCKS) : cfg_wdata;

  assign bb_a     = AW'(bb_r);
  assign t8       = 8'(bt_r);
  assign r8       = 8'(r_idx_r);
  assign w8       = 8'(w_idx_r);
  assign n8       = idx_next(w8, t8);
  assign nr8      = idx_next(r8, t8);
  assign do_store = fill_r < bb_r;
  assign fill_inc = fill_r + {{(LEN_W-1){1'b0}}, do_store};
  assign rlen     = (in_read_length > bb_r) ? bb_r : in_read_length;

  always_comb begin
    bb_nxt       = bb_r;
    bt_nxt       = bt_r;
    r_idx_nxt    = r_idx_r;
    w_idx_nxt    = w_idx_r;
    rd_base_nxt  = rd_base_r;
    wr_base_nxt  = wr_base_r;
    fill_nxt     = fill_r;
    rmiss_nxt    = rmiss_r;
    wmiss_nxt    = wmiss_r;
    clr_nxt      = clr_r;
    clr_addr_nxt = clr_addr_r;
    ram_we       = 1'b0;
    ram_waddr    = wr_base_r + AW'(fill_r);
    ram_wdata    = in_data;
    jq_push      = 1'b0;
    jq_rd        = 1'b0;
    jq_len       = rlen;
    jq_base      = rd_base_r;
    jq_slot      = r_idx_r;
    st           = ST_OK;
    bcnt         = '0;
    if (clr_r) begin
      ram_we       = 1'b1;
      ram_waddr    = clr_addr_r;
      ram_wdata    = '0;
      clr_addr_nxt = clr_addr_r + AW'(1);
      if (clr_addr_r == LAST_ADDR) begin
        clr_nxt = 1'b0;
      end
    end else if (accept) begin
      case (in_command)
        CMD_WRITE: begin
          ram_we = do_store;
          if (in_last) begin
            fill_nxt = '0;
            jq_push  = 1'b1;
            if (n8 == r8) begin
              wmiss_nxt = wmiss_r + MISS_W'(1);
              st        = ST_FULL;
            end else begin
              w_idx_nxt   = IW'(n8);
              wr_base_nxt = (n8 == 8'd0) ? '0 : wr_base_r + bb_a;
              bcnt        = fill_inc;
            end
          end else begin
            fill_nxt = fill_inc;
          end
        end
        CMD_READ: begin
          jq_push = 1'b1;
          if (r8 == w8) begin
            rmiss_nxt = rmiss_r + MISS_W'(1);
            st        = ST_EMPTY;
          end else if (rlen == '0) begin
            st = ST_ZERO;
          end else begin
            jq_rd       = 1'b1;
            bcnt        = rlen;
            r_idx_nxt   = IW'(nr8);
            rd_base_nxt = (nr8 == 8'd0) ? '0 : rd_base_r + bb_a;
          end
        end
        CMD_CLEAR: begin
          jq_push     = 1'b1;
          r_idx_nxt   = w_idx_r;
          rd_base_nxt = wr_base_r;
        end
        default: begin
        end
      endcase
    end
    if (cfg_hit) begin
      if (cfg_index == REG_BLOCK_BYTES) begin
        bb_nxt = cv_bb;
      end else begin
        bt_nxt = cv_bt;
      end
      r_idx_nxt    = '0;
      w_idx_nxt    = '0;
      rd_base_nxt  = '0;
      wr_base_nxt  = '0;
      fill_nxt     = '0;
      rmiss_nxt    = '0;
      wmiss_nxt    = '0;
      clr_nxt      = 1'b1;
      clr_addr_nxt = '0;
    end
  end

  // Fill levels reported with a result are those after the request took effect.
  assign r8n = 8'(r_idx_nxt);
  assign w8n = 8'(w_idx_nxt);
  assign n8n = idx_next(w8n, t8);

  always_comb begin
    jq_info.status       = st;
    jq_info.byte_count   = bcnt;
    jq_info.read_misses  = rmiss_nxt;
    jq_info.write_misses = wmiss_nxt;
    if (r8n == w8n) begin
      jq_info.blocks_readable     = '0;
      jq_info.contiguous_readable = '0;
    end else if (w8n > r8n) begin
      jq_info.blocks_readable     = CNT_W'(w8n - r8n);
      jq_info.contiguous_readable = CNT_W'(w8n - r8n);
    end else begin
      jq_info.blocks_readable     = CNT_W'(t8 + w8n - r8n);
      jq_info.contiguous_readable = CNT_W'(t8 - r8n);
    end
    if (n8n == r8n) begin
      jq_info.blocks_writable     = '0;
      jq_info.contiguous_writable = '0;
    end else if (r8n > n8n) begin
      jq_info.blocks_writable     = CNT_W'(r8n - n8n);
      jq_info.contiguous_writable = CNT_W'(r8n - n8n);
    end else begin
      jq_info.blocks_writable     = CNT_W'(t8 + r8n - n8n);
      jq_info.contiguous_writable = CNT_W'(t8 - n8n);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bb_r       <= BB_RST_V;
      bt_r       <= BT_RST_V;
      r_idx_r    <= '0;
      w_idx_r    <= '0;
      rd_base_r  <= '0;
      wr_base_r  <= '0;
      fill_r     <= '0;
      rmiss_r    <= '0;
      wmiss_r    <= '0;
      clr_r      <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      bb_r       <= bb_nxt;
      bt_r       <= bt_nxt;
      r_idx_r    <= r_idx_nxt;
      w_idx_r    <= w_idx_nxt;
      rd_base_r  <= rd_base_nxt;
      wr_base_r  <= wr_base_nxt;
      fill_r     <= fill_nxt;
      rmiss_r    <= rmiss_nxt;
      wmiss_r    <= wmiss_nxt;
      clr_r      <= clr_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  `RBUF_ASSERT(a_fill_in_block, clk, rst_n, fill_r <= bb_r, "write fill beyond block size")
  `RBUF_ASSERT_NEXT(a_size_write_clears, clk, rst_n, cfg_hit, clr_r && (fill_r == '0), "size write did not start a clearing pass")

endmodule

@@ design/rbuf_jobq.sv @@
// Two-entry job queue between the front and the back end.
// Also reports whether a queued block read covers a given slot. Depends on rbuf_pkg.
module rbuf_jobq import rbuf_pkg::*; #(
  parameter int MAX_BLOCK_BYTES = 64,
  parameter int MAX_BLOCKS      = 64
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          push,
  input  res_info_t                                     push_info,
  input  logic                                          push_rd,
  input  logic [LEN_W-1:0]                              push_len,
  input  logic [$clog2(MAX_BLOCKS*MAX_BLOCK_BYTES)-1:0] push_base,
  input  logic [$clog2(MAX_BLOCKS)-1:0]                 push_slot,
  input  logic                                          pop,
  output logic                                          nempty,
  output logic                                          q_full,
  output res_info_t                                     head_info,
  output logic                                          head_rd,
  output logic [LEN_W-1:0]                              head_len,
  output logic [$clog2(MAX_BLOCKS*MAX_BLOCK_BYTES)-1:0] head_base,
  output logic [$clog2(MAX_BLOCKS)-1:0]                 head_slot,
  input  logic [$clog2(MAX_BLOCKS)-1:0]                 query_slot,
  output logic                                          hit
);

  localparam int AW = $clog2(MAX_BLOCKS * MAX_BLOCK_BYTES);
  localparam int IW = $clog2(MAX_BLOCKS);

  typedef struct packed {
    res_info_t        info;
    logic             rd;
    logic [LEN_W-1:0] len;
    logic [AW-1:0]    base;
    logic [IW-1:0]    slot;
  } job_t;

  job_t       e0_r, e0_nxt, e1_r, e1_nxt, din;
  logic [1:0] occ_r, occ_nxt;
  logic       pop_ok;

  assign din    = '{info: push_info, rd: push_rd, len: push_len, base: push_base,
                    slot: push_slot};
  assign pop_ok = pop & (occ_r != 2'd0);
  assign nempty = occ_r != 2'd0;
  assign q_full = occ_r == 2'd2;

  assign head_info = e0_r.info;
  assign head_rd   = e0_r.rd;
  assign head_len  = e0_r.len;
  assign head_base = e0_r.base;
  assign head_slot = e0_r.slot;

  assign hit = ((occ_r != 2'd0) & e0_r.rd & (e0_r.slot == query_slot)) |
               ((occ_r == 2'd2) & e1_r.rd & (e1_r.slot == query_slot));

  always_comb begin
    e0_nxt  = e0_r;
    e1_nxt  = e1_r;
    occ_nxt = occ_r;
    case ({push, pop_ok})
      2'b10: begin
        if (occ_r == 2'd0) begin
          e0_nxt = din;
        end else begin
          e1_nxt = din;
        end
        occ_nxt = occ_r + 2'd1;
      end
      2'b01: begin
        e0_nxt  = e1_r;
        occ_nxt = occ_r - 2'd1;
      end
      2'b11: begin
        if (occ_r == 2'd1) begin
          e0_nxt = din;
        end else begin
          e0_nxt = e1_r;
          e1_nxt = din;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else begin
      occ_r <= occ_nxt;
    end
    e0_r <= e0_nxt;
    e1_r <= e1_nxt;
  end

endmodule

@@ design/rbuf_back.sv @@
// Back end: carries out queued jobs, reads block bytes from the store one per cycle
// while the output queue has room, holds results in a two-entry output queue. Depends on rbuf_pkg and macros.
`include "block_ring_buffer_macros.svh"
module rbuf_back import rbuf_pkg::*; #(
  parameter int MAX_BLOCK_BYTES = 64,
  parameter int MAX_BLOCKS      = 64
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          q_nempty,
  input  res_info_t                                     q_info,
  input  logic                                          q_rd,
  input  logic [LEN_W-1:0]                              q_len,
  input  logic [$clog2(MAX_BLOCKS*MAX_BLOCK_BYTES)-1:0] q_base,
  input  logic [$clog2(MAX_BLOCKS)-1:0]                 q_slot,
  output logic                                          q_pop,
  input  logic [$clog2(MAX_BLOCKS)-1:0]                 query_slot,
  output logic                                          bk_hit,
  output logic                                          ram_re,
  output logic [$clog2(MAX_BLOCKS*MAX_BLOCK_BYTES)-1:0] ram_raddr,
  input  logic [DATA_W-1:0]                             ram_rdata,
  output logic                                          empty,
  input  logic                                          pop,
  output res_t                                          res
);

  localparam int AW = $clog2(MAX_BLOCKS * MAX_BLOCK_BYTES);
  localparam int IW = $clog2(MAX_BLOCKS);

  logic             job_v_r, job_v_nxt, job_rd_r;
  res_info_t        job_info_r;
  logic [LEN_W-1:0] job_len_r, idx_r, idx_nxt;
  logic [AW-1:0]    job_base_r;
  logic [IW-1:0]    job_slot_r;

  logic             s1_v_r, s1_fin_r, s1_ram_r;
  res_info_t        s1_info_r;

  res_t             o0_r, o0_nxt, o1_r, o1_nxt, rnew;
  logic [1:0]       occ_r, occ_nxt;
  logic [2:0]       occ_after;
  logic             pop_ok, issue, last_el, take;

  assign pop_ok    = pop & (occ_r != 2'd0);
  assign occ_after = {1'b0, occ_r} + {2'b0, s1_v_r} - {2'b0, pop_ok};
  assign issue     = job_v_r & (occ_after <= 3'd1);
  assign last_el   = ~job_rd_r | ((idx_r + 7'd1) == job_len_r);
  assign take      = q_nempty & (~job_v_r | (issue & last_el));
  assign q_pop     = take;
  assign job_v_nxt = take | (job_v_r & ~(issue & last_el));
  assign idx_nxt   = (issue & last_el) ? '0 : (issue ? idx_r + 7'd1 : idx_r);

  assign ram_re    = issue & job_rd_r;
  assign ram_raddr = job_base_r + AW'(idx_r);
  assign bk_hit    = job_v_r & job_rd_r & (job_slot_r == query_slot);

  assign rnew.read_byte = s1_ram_r ? ram_rdata : '0;
  assign rnew.final_res = s1_fin_r;
  assign rnew.info      = s1_info_r;

  assign empty = occ_r == 2'd0;
  assign res   = o0_r;

  always_comb begin
    o0_nxt  = o0_r;
    o1_nxt  = o1_r;
    occ_nxt = occ_r;
    case ({s1_v_r, pop_ok})
      2'b10: begin
        if (occ_r == 2'd0) begin
          o0_nxt = rnew;
        end else begin
          o1_nxt = rnew;
        end
        occ_nxt = occ_r + 2'd1;
      end
      2'b01: begin
        o0_nxt  = o1_r;
        occ_nxt = occ_r - 2'd1;
      end
      2'b11: begin
        if (occ_r == 2'd1) begin
          o0_nxt = rnew;
        end else begin
          o0_nxt = o1_r;
          o1_nxt = rnew;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_v_r <= 1'b0;
      idx_r   <= '0;
      s1_v_r  <= 1'b0;
      occ_r   <= '0;
    end else begin
      job_v_r <= job_v_nxt;
      idx_r   <= idx_nxt;
      s1_v_r  <= issue;
      occ_r   <= occ_nxt;
    end
    if (take) begin
      job_info_r <= q_info;
      job_rd_r   <= q_rd;
      job_len_r  <= q_len;
      job_base_r <= q_base;
      job_slot_r <= q_slot;
    end
    if (issue) begin
      s1_fin_r  <= last_el;
      s1_ram_r  <= job_rd_r;
      s1_info_r <= job_info_r;
    end
    o0_r <= o0_nxt;
    o1_r <= o1_nxt;
  end

  `RBUF_ASSERT(a_out_room, clk, rst_n, !(s1_v_r && (occ_r == 2'd2) && !pop_ok), "result arrived at a full output queue")
  `RBUF_ASSERT(a_idx_in_len, clk, rst_n, !(job_v_r && job_rd_r) || (idx_r < job_len_r), "block read ran past its length")

endmodule

@@ design/block_ring_buffer.sv @@
// Block ring buffer top level: front end, job queue, back end and byte store.
// Depends on rbuf_pkg, rbuf_front, rbuf_jobq, rbuf_back and rbuf_ram.
//
//   Channel   Handshake           Payload
//   request   push / full         in_command, in_data, in_last, in_read_length
//   result    empty / pop         out_read_byte ... out_write_misses
//   config    cfg_wr_en           cfg_index, cfg_wdata
//
// A request is taken when full is low; each result passes the job queue, the back end's
// job and read registers and the output queue. A block read gives one byte a cycle from
// the store's read port while the output queue has room. After reset and after every
// nonzero size write, a clearing pass zeroes the store, with full held high.
// Full also rises while two jobs are queued, or while the slot being written is read out.
module block_ring_buffer import rbuf_pkg::*; #(
  parameter int MAX_BLOCK_BYTES = 64,
  parameter int MAX_BLOCKS      = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  push,
  output logic                  full,
  input  logic [CMD_W-1:0]      in_command,
  input  logic [DATA_W-1:0]     in_data,
  input  logic                  in_last,
  input  logic [LEN_W-1:0]      in_read_length,
  output logic                  empty,
  input  logic                  pop,
  output logic [DATA_W-1:0]     out_read_byte,
  output logic                  out_final_res,
  output logic [ST_W-1:0]       out_status,
  output logic [LEN_W-1:0]      out_byte_count,
  output logic [CNT_W-1:0]      out_blocks_readable,
  output logic [CNT_W-1:0]      out_blocks_writable,
  output logic [CNT_W-1:0]      out_contiguous_readable,
  output logic [CNT_W-1:0]      out_contiguous_writable,
  output logic [MISS_W-1:0]     out_read_misses,
  output logic [MISS_W-1:0]     out_write_misses
);

  localparam int SD = MAX_BLOCKS * MAX_BLOCK_BYTES;
  localparam int AW = $clog2(SD);
  localparam int IW = $clog2(MAX_BLOCKS);

  logic              q_full, q_hit, bk_hit, q_nempty, q_pop;
  logic [IW-1:0]     wr_slot;
  logic              jq_push, jq_rd;
  res_info_t         jq_info;
  logic [LEN_W-1:0]  jq_len;
  logic [AW-1:0]     jq_base;
  logic [IW-1:0]     jq_slot;
  res_info_t         h_info;
  logic              h_rd;
  logic [LEN_W-1:0]  h_len;
  logic [AW-1:0]     h_base;
  logic [IW-1:0]     h_slot;
  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [DATA_W-1:0] ram_wdata, ram_rdata;
  res_t              res;

  rbuf_front #(.MAX_BLOCK_BYTES(MAX_BLOCK_BYTES), .MAX_BLOCKS(MAX_BLOCKS)) u_front (
    .clk, .rst_n, .cfg_wr_en, .cfg_index, .cfg_wdata, .push, .full,
    .in_command, .in_data, .in_last, .in_read_length,
    .q_full, .q_hit, .bk_hit, .wr_slot,
    .jq_push, .jq_info, .jq_rd, .jq_len, .jq_base, .jq_slot,
    .ram_we, .ram_waddr, .ram_wdata
  );

  rbuf_jobq #(.MAX_BLOCK_BYTES(MAX_BLOCK_BYTES), .MAX_BLOCKS(MAX_BLOCKS)) u_jobq (
    .clk, .rst_n,
    .push(jq_push), .push_info(jq_info), .push_rd(jq_rd), .push_len(jq_len),
    .push_base(jq_base), .push_slot(jq_slot),
    .pop(q_pop), .nempty(q_nempty), .q_full,
    .head_info(h_info), .head_rd(h_rd), .head_len(h_len), .head_base(h_base),
    .head_slot(h_slot), .query_slot(wr_slot), .hit(q_hit)
  );

  rbuf_back #(.MAX_BLOCK_BYTES(MAX_BLOCK_BYTES), .MAX_BLOCKS(MAX_BLOCKS)) u_back (
    .clk, .rst_n,
    .q_nempty, .q_info(h_info), .q_rd(h_rd), .q_len(h_len), .q_base(h_base),
    .q_slot(h_slot), .q_pop, .query_slot(wr_slot), .bk_hit,
    .ram_re, .ram_raddr, .ram_rdata, .empty, .pop, .res
  );

  rbuf_ram #(.WIDTH(DATA_W), .DEPTH(SD)) u_store (
    .clk, .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .re(ram_re), .raddr(ram_raddr), .rdata(ram_rdata)
  );

  assign out_read_byte           = res.read_byte;
  assign out_final_res           = res.final_res;
  assign out_status              = res.info.status;
  assign out_byte_count          = res.info.byte_count;
  assign out_blocks_readable     = res.info.blocks_readable;
  assign out_blocks_writable     = res.info.blocks_writable;
  assign out_contiguous_readable = res.info.contiguous_readable;
  assign out_contiguous_writable = res.info.contiguous_writable;
  assign out_read_misses         = res.info.read_misses;
  assign out_write_misses        = res.info.write_misses;

endmodule
